[sv/lbco_pkg.sv]
// Shared types and constants for the beam circle occluder.
package lbco_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_BEAM   = 2'd2;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_TOL    = 1'b1;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch beam, compute angle
    OP_Z,        // z from remainder
    OP_Z2,       // z squared
    OP_SERM,     // Horner product and power-of-two pre-shift
    OP_SER,      // Horner reciprocal divide and update (sin or cos per flag)
    OP_DIR,      // finalize direction
    OP_OBS_RD,   // read obstacle entry
    OP_PROD,     // four products
    OP_BP,       // B and P
    OP_SQ,       // start sqrt
    OP_SQSTEP,   // one sqrt step
    OP_TEST      // hit test and update
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_Z, ST_Z2, ST_SERM, ST_SER, ST_DIR, ST_RD, ST_PROD, ST_BP,
    ST_SQ, ST_SQSTEP, ST_TEST, ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] step;   // horner step index
    logic       fn_cos; // horner on cos series
  } cmd_t;

  typedef struct packed {
    logic skip;     // current range zero or P beyond radius
    logic done;     // all obstacles visited
    logic sq_last;  // last sqrt step
  } stat_t;

endpackage

[sv/lbco_datapath.sv]
// Datapath: trig series, obstacle table, ray-circle test and square root.
module lbco_datapath #(
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbco_pkg::cmd_t      cmd_i,
  output lbco_pkg::stat_t     stat_o,
  input  logic                tbl_clear_i,
  input  logic                tbl_append_i,
  input  logic signed [23:0]  obstacle_x_i,
  input  logic signed [23:0]  obstacle_y_i,
  input  logic signed [23:0]  sensor_x_i,
  input  logic signed [23:0]  sensor_y_i,
  input  logic [15:0]         heading_i,
  input  logic [15:0]         beam_offset_i,
  input  logic [19:0]         beam_range_i,
  input  logic [15:0]         radius_i,
  input  logic [15:0]         tol_i,
  output logic [19:0]         range_o,
  output logic                hit_o
);
  localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW = $clog2(MAX_OBSTACLES + 1);

  logic signed [23:0] tx_mem [MAX_OBSTACLES];
  logic signed [23:0] ty_mem [MAX_OBSTACLES];
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q, idx_d;
  logic signed [23:0] ox_q, oy_q;

  logic signed [23:0] px_q, py_q;
  logic [19:0] range_q, range_d;
  logic hit_q, hit_d;
  logic [1:0] quad_q;
  logic swap_q;
  logic [13:0] r_q;
  logic [31:0] z_q, z2_q;
  logic [31:0] tsin_q, tcos_q;
  logic [28:0] hdiv_q;
  logic signed [31:0] c_q, s_q;
  logic signed [63:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [41:0] b_q;
  logic [23:0] p_q;
  logic [47:0] sqv_q, sqres_q, sqbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (tbl_clear_i) begin
      cnt_q <= '0;
    end else if (tbl_append_i && cnt_q < CW'(MAX_OBSTACLES)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_append_i && !tbl_clear_i && cnt_q < CW'(MAX_OBSTACLES)) begin
      tx_mem[cnt_q[IW-1:0]] <= obstacle_x_i;
      ty_mem[cnt_q[IW-1:0]] <= obstacle_y_i;
    end
    if (cmd_i.op == lbco_pkg::OP_OBS_RD) begin
      ox_q <= tx_mem[idx_q[IW-1:0]];
      oy_q <= ty_mem[idx_q[IW-1:0]];
    end
  end

  // Horner step: divide by constant = strip power of two, then reciprocal
  // multiply by the odd part (exact for dividends below 2^29)
  logic [63:0] hprod;
  logic [31:0] hsrc, hdiv_in, hquo;
  logic [1:0]  hpre;
  logic [29:0] hmul;
  logic [5:0]  hpost;
  logic [58:0] hrecip;
  always_comb begin
    hsrc = cmd_i.fn_cos ? tcos_q : tsin_q;
    hprod = 64'(z2_q) * 64'(hsrc);
    hdiv_in = (cmd_i.step == 3'd0) ? z2_q : hprod[61:30];
    hpre = 2'd1;
    hmul = 30'd715827883;
    hpost = 6'd31;
    if (cmd_i.fn_cos) begin
      case (cmd_i.step)
        3'd0: begin hpre = 2'd3; hmul = 30'd613566757; hpost = 6'd32; end  // 56
        3'd1: begin hpre = 2'd1; hmul = 30'd572662307; hpost = 6'd33; end  // 30
        3'd2: begin hpre = 2'd2; hmul = 30'd715827883; hpost = 6'd31; end  // 12
        default: begin hpre = 2'd1; hmul = 30'd536870912; hpost = 6'd29; end  // 2
      endcase
    end else begin
      case (cmd_i.step)
        3'd0: begin hpre = 2'd1; hmul = 30'd818089009; hpost = 6'd34; end  // 42
        3'd1: begin hpre = 2'd2; hmul = 30'd858993460; hpost = 6'd32; end  // 20
        default: begin hpre = 2'd1; hmul = 30'd715827883; hpost = 6'd31; end  // 6
      endcase
    end
    hrecip = 59'(hdiv_q) * 59'(hmul);
    hquo = 32'(hrecip >> hpost);
  end

  logic [15:0] ang;
  logic [13:0] rr;
  logic [63:0] sinprod;
  logic signed [31:0] c0, s0;
  logic signed [31:0] cc, ss;
  always_comb begin
    ang = heading_i + beam_offset_i;
    rr = (r_q <= 14'd8192) ? r_q : 14'(15'd16384 - {1'b0, r_q});
    sinprod = 64'(z_q) * 64'(tsin_q);
    s0 = swap_q ? $signed(tcos_q) : $signed(sinprod[61:30]);
    c0 = swap_q ? $signed(sinprod[61:30]) : $signed(tcos_q);
    case (quad_q)
      2'd0: begin cc = c0; ss = s0; end
      2'd1: begin cc = -s0; ss = c0; end
      2'd2: begin cc = -c0; ss = -s0; end
      default: begin cc = s0; ss = -c0; end
    endcase
  end

  // floor shift by 22 is arithmetic shift
  logic signed [63:0] bsum, psum;
  logic signed [41:0] pabs;
  logic [23:0] rad;
  logic skip_now;
  assign rad = {radius_i, 8'd0};
  always_comb begin
    bsum = m0_q + m1_q;
    psum = m2_q - m3_q;
    pabs = 42'(psum >>> 22);
    if (pabs < 0) pabs = -pabs;
    skip_now = (pabs > 42'(rad)) || (range_q == '0);
  end

  // sqrt step
  logic [47:0] sq_trial;
  assign sq_trial = sqres_q + sqbit_q;

  // hit test
  logic signed [49:0] d_s, len_s;
  logic signed [67:0] lhs;
  logic hit_now;
  logic [49:0] ad;
  always_comb begin
    d_s = -50'(b_q) - 50'($signed({1'b0, sqres_q}));
    len_s = $signed({22'd0, range_q, 8'd0});
    lhs = (68'(d_s) <<< 16) + 68'($signed({1'b0, tol_i})) * 68'(len_s);
    hit_now = (lhs >= 0) && (d_s < len_s);
    ad = d_s < 0 ? 50'(-d_s) : 50'(d_s);
  end

  always_comb begin
    range_d = range_q;
    hit_d = hit_q;
    idx_d = idx_q;
    if (cmd_i.op == lbco_pkg::OP_LOAD) begin
      range_d = beam_range_i;
      hit_d = 1'b0;
      idx_d = '0;
    end else if (cmd_i.op == lbco_pkg::OP_TEST) begin
      if (hit_now) begin
        range_d = 20'((ad + 50'd128) >> 8);
        hit_d = 1'b1;
      end
      idx_d = idx_q + 1'b1;
    end else if (cmd_i.op == lbco_pkg::OP_BP && skip_now) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    hit_q <= hit_d;
    idx_q <= idx_d;
    case (cmd_i.op)
      lbco_pkg::OP_LOAD: begin
        px_q <= sensor_x_i; py_q <= sensor_y_i;
        quad_q <= ang[15:14]; r_q <= ang[13:0];
        swap_q <= ang[13:0] > 14'd8192;
      end
      lbco_pkg::OP_Z: z_q <= 32'((64'(rr) * 64'(lbco_pkg::PI_Q30)) >> 15);
      lbco_pkg::OP_Z2: z2_q <= 32'((64'(z_q) * 64'(z_q)) >> 30);
      lbco_pkg::OP_SERM: hdiv_q <= 29'(hdiv_in >> hpre);
      lbco_pkg::OP_SER: begin
        if (cmd_i.fn_cos) tcos_q <= lbco_pkg::Q30_ONE - hquo;
        else tsin_q <= lbco_pkg::Q30_ONE - hquo;
      end
      lbco_pkg::OP_DIR: begin c_q <= cc; s_q <= ss; end
      lbco_pkg::OP_PROD: begin
        m0_q <= 64'(c_q) * 64'(px_q - ox_q);
        m1_q <= 64'(s_q) * 64'(py_q - oy_q);
        m2_q <= 64'(c_q) * 64'(py_q - oy_q);
        m3_q <= 64'(s_q) * 64'(px_q - ox_q);
      end
      lbco_pkg::OP_BP: begin
        b_q <= 42'(bsum >>> 22);
        p_q <= pabs[23:0];
      end
      lbco_pkg::OP_SQ: begin
        sqv_q <= 48'(rad) * 48'(rad) - 48'(p_q) * 48'(p_q);
        sqres_q <= '0;
        sqbit_q <= 48'd1 << 46;
      end
      lbco_pkg::OP_SQSTEP: begin
        if (sqv_q >= sq_trial) begin
          sqv_q <= sqv_q - sq_trial;
          sqres_q <= (sqres_q >> 1) + sqbit_q;
        end else begin
          sqres_q <= sqres_q >> 1;
        end
        sqbit_q <= sqbit_q >> 2;
      end
      default: ;
    endcase
  end

  assign stat_o.done = (idx_q >= cnt_q);
  assign stat_o.skip = skip_now;
  assign stat_o.sq_last = sqbit_q[0];
  assign range_o = range_q;
  assign hit_o = hit_q;
endmodule

[sv/lbco_ctrl.sv]
// Controller: sequences direction setup, obstacle walk and sqrt steps.
module lbco_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      cmd_i,
  output logic            in_stall_o,
  output logic            tbl_clear_o,
  output logic            tbl_append_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lbco_pkg::cmd_t  dp_o,
  input  lbco_pkg::stat_t stat_i
);
  lbco_pkg::state_e st_q, st_d;
  logic [2:0] step_q, step_d;
  logic cos_q, cos_d;
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lbco_pkg::ST_IDLE; step_q <= '0; cos_q <= 1'b0;
    end else begin
      st_q <= st_d; step_q <= step_d; cos_q <= cos_d;
    end
  end

  always_comb begin
    st_d = st_q; step_d = step_q; cos_d = cos_q;
    dp_o = '{op: lbco_pkg::OP_NONE, step: step_q, fn_cos: cos_q};
    in_stall_o = (st_q != lbco_pkg::ST_IDLE);
    out_valid_o = (st_q == lbco_pkg::ST_OUT);
    acc = in_valid_i && !in_stall_o;
    tbl_clear_o = acc && cmd_i == lbco_pkg::CMD_CLEAR;
    tbl_append_o = acc && cmd_i == lbco_pkg::CMD_APPEND;
    case (st_q)
      lbco_pkg::ST_IDLE: if (acc && cmd_i == lbco_pkg::CMD_BEAM) begin
        dp_o.op = lbco_pkg::OP_LOAD; st_d = lbco_pkg::ST_Z;
      end
      lbco_pkg::ST_Z: begin dp_o.op = lbco_pkg::OP_Z; st_d = lbco_pkg::ST_Z2; end
      lbco_pkg::ST_Z2: begin
        dp_o.op = lbco_pkg::OP_Z2; st_d = lbco_pkg::ST_SERM;
        step_d = '0; cos_d = 1'b0;
      end
      lbco_pkg::ST_SERM: begin dp_o.op = lbco_pkg::OP_SERM; st_d = lbco_pkg::ST_SER; end
      lbco_pkg::ST_SER: begin
        dp_o.op = lbco_pkg::OP_SER;
        if (!cos_q && step_q == 3'd2) begin
          cos_d = 1'b1; step_d = '0; st_d = lbco_pkg::ST_SERM;
        end else if (cos_q && step_q == 3'd3) begin
          st_d = lbco_pkg::ST_DIR;
        end else begin
          step_d = step_q + 1'b1; st_d = lbco_pkg::ST_SERM;
        end
      end
      lbco_pkg::ST_DIR: begin dp_o.op = lbco_pkg::OP_DIR; st_d = lbco_pkg::ST_RD; end
      lbco_pkg::ST_RD: begin
        if (stat_i.done) st_d = lbco_pkg::ST_OUT;
        else begin dp_o.op = lbco_pkg::OP_OBS_RD; st_d = lbco_pkg::ST_PROD; end
      end
      lbco_pkg::ST_PROD: begin dp_o.op = lbco_pkg::OP_PROD; st_d = lbco_pkg::ST_BP; end
      lbco_pkg::ST_BP: begin
        dp_o.op = lbco_pkg::OP_BP;
        st_d = stat_i.skip ? lbco_pkg::ST_RD : lbco_pkg::ST_SQ;
      end
      lbco_pkg::ST_SQ: begin dp_o.op = lbco_pkg::OP_SQ; st_d = lbco_pkg::ST_SQSTEP; end
      lbco_pkg::ST_SQSTEP: begin
        dp_o.op = lbco_pkg::OP_SQSTEP;
        if (stat_i.sq_last) st_d = lbco_pkg::ST_TEST;
      end
      lbco_pkg::ST_TEST: begin dp_o.op = lbco_pkg::OP_TEST; st_d = lbco_pkg::ST_RD; end
      lbco_pkg::ST_OUT: if (!out_stall_i) st_d = lbco_pkg::ST_IDLE;
      default: st_d = lbco_pkg::ST_IDLE;
    endcase
  end
endmodule

[sv/lidar_beam_circle_occluder.sv]
// Top level of the beam circle occluder.
// Input channel: in_valid_i / in_stall_o with cmd and payload ports. A beat
// with cmd clear or append updates the obstacle table and gives no result;
// cmd 3 is dropped. A beam beat is followed by a result on out_valid_o /
// out_stall_i carrying new_range_o and hit_o.
// Configuration: cfg_valid_i / cfg_ready_o, index 0 radius, 1 tolerance.
// A beam runs through direction setup (angle, z, z squared, seven Horner
// steps, rotation), then reads each stored obstacle and forms its products
// and B and P; for each obstacle the ray passes within the radius while the
// range is nonzero it adds sqrt setup, 24 root steps and a hit test. The walk
// ends once every obstacle is visited. The next beat is taken the cycle after
// the result beat. Input stalls while a beam is in work or its result waits.
// A stalled result holds. Reset clears the obstacle count and restores the
// radius and tolerance defaults; the table contents are not cleared.
module lidar_beam_circle_occluder #(
  parameter int MAX_OBSTACLES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [23:0] obstacle_x_i,
  input  logic signed [23:0] obstacle_y_i,
  input  logic signed [23:0] sensor_x_i,
  input  logic signed [23:0] sensor_y_i,
  input  logic [15:0]        heading_i,
  input  logic [15:0]        beam_offset_i,
  input  logic [19:0]        beam_range_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [19:0]        new_range_o,
  output logic               hit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  logic [15:0] radius_q, tol_q;
  lbco_pkg::cmd_t  dp_cmd;
  lbco_pkg::stat_t dp_stat;
  logic clr, app;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd2560; tol_q <= 16'd66;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lbco_pkg::CFG_RADIUS) radius_q <= cfg_data_i;
      else if (cfg_index_i == lbco_pkg::CFG_TOL) tol_q <= cfg_data_i;
    end
  end

  lbco_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .cmd_i, .in_stall_o,
    .tbl_clear_o(clr), .tbl_append_o(app), .out_valid_o, .out_stall_i,
    .dp_o(dp_cmd), .stat_i(dp_stat)
  );

  lbco_datapath #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .stat_o(dp_stat),
    .tbl_clear_i(clr), .tbl_append_i(app),
    .obstacle_x_i, .obstacle_y_i, .sensor_x_i, .sensor_y_i,
    .heading_i, .beam_offset_i, .beam_range_i,
    .radius_i(radius_q), .tol_i(tol_q),
    .range_o(new_range_o), .hit_o
  );
endmodule
